### src/sset_pkg.sv
// Shared types and codes of the sorted key set.
`default_nettype none

package sset_pkg;

    // Fixed field widths of the command and result channels
    localparam int CMD_W    = 2;
    localparam int KEYIO_W  = 32;
    localparam int IDX_W    = 6;
    localparam int STAT_W   = 3;
    localparam int TOTAL_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_INSERTED     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL         = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CLEARED      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_READ_OK      = 3'd4;
    localparam logic [STAT_W-1:0] STAT_OUT_OF_RANGE = 3'd5;

    // Engine sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_PLACE,
        S_READ_WAIT,
        S_DONE
    } sset_state_t;

    // One finished result, handed from the engine to the output stage
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [IDX_W-1:0]   position;
        logic [TOTAL_W-1:0] total;
        logic [KEYIO_W-1:0] read_key;
    } sset_result_t;

endpackage

`default_nettype wire

### src/sset_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered: data valid in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/sset_engine.sv
// Sequencer of the sorted key set: bisection, shift-up, place, clear, read.
`default_nettype none

module sset_engine #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // command side
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [sset_pkg::CMD_W-1:0]            cmd,
    input  wire logic signed [sset_pkg::KEYIO_W-1:0]   key,
    input  wire logic [sset_pkg::IDX_W-1:0]            index,
    // result side
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output sset_pkg::sset_result_t                     res,
    // key store
    output logic                                       ram_wr_en,
    output logic [$clog2(CAPACITY)-1:0]                ram_wr_addr,
    output logic [KEY_WIDTH-1:0]                       ram_wr_data,
    output logic                                       ram_rd_en,
    output logic [$clog2(CAPACITY)-1:0]                ram_rd_addr,
    input  wire logic [KEY_WIDTH-1:0]                  ram_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sset_pkg::sset_state_t state_reg, state_next;

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              left_reg, left_next;
    logic [CW-1:0]              right_reg, right_next;
    logic [AW-1:0]              mid_reg, mid_next;
    logic [AW-1:0]              rp_reg, rp_next;
    logic [AW-1:0]              last_reg, last_next;
    logic                       reading_reg, reading_next;
    logic                       pend_reg, pend_next;
    logic [KEY_WIDTH-1:0]       key_reg, key_next;
    logic [sset_pkg::IDX_W-1:0] idx_reg, idx_next;
    sset_pkg::sset_result_t     res_reg, res_next;

    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;
    logic          in_range;
    logic          key_eq;
    logic          key_lt;

    // Midpoint of the open search window
    assign mid_sum  = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid_calc = AW'(mid_sum[CW:1]);

    // Read index lies below the count and inside the store
    assign in_range = (int'(index) < int'(count_reg)) && (int'(index) < CAPACITY);

    // Signed compare of the probed entry against the held key
    assign key_eq = (ram_rd_data == key_reg);
    assign key_lt = ($signed(key_reg) < $signed(ram_rd_data));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sset_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        sset_pkg::CMD_INSERT: state_next = sset_pkg::S_SRCH_RD;
                        sset_pkg::CMD_CLEAR:  state_next = sset_pkg::S_DONE;
                        sset_pkg::CMD_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = sset_pkg::S_READ_WAIT;
                            end
                            else
                            begin
                                state_next = sset_pkg::S_DONE;
                            end
                        end
                        default:              state_next = sset_pkg::S_IDLE;
                    endcase
                end
            end
            sset_pkg::S_SRCH_RD:
            begin
                if (left_reg < right_reg)
                begin
                    state_next = sset_pkg::S_SRCH_CMP;
                end
                else if (count_reg >= CAP_C)
                begin
                    state_next = sset_pkg::S_DONE;
                end
                else if (count_reg > left_reg)
                begin
                    state_next = sset_pkg::S_SHIFT;
                end
                else
                begin
                    state_next = sset_pkg::S_PLACE;
                end
            end
            sset_pkg::S_SRCH_CMP:
            begin
                if (key_eq)
                begin
                    state_next = sset_pkg::S_DONE;
                end
                else
                begin
                    state_next = sset_pkg::S_SRCH_RD;
                end
            end
            sset_pkg::S_SHIFT:
            begin
                if (!reading_reg)
                begin
                    state_next = sset_pkg::S_PLACE;
                end
            end
            sset_pkg::S_PLACE:     state_next = sset_pkg::S_DONE;
            sset_pkg::S_READ_WAIT: state_next = sset_pkg::S_DONE;
            sset_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = sset_pkg::S_IDLE;
                end
            end
            default:               state_next = sset_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        count_next   = count_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        mid_next     = mid_reg;
        rp_next      = rp_reg;
        last_next    = last_reg;
        reading_next = reading_reg;
        pend_next    = pend_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = last_reg + 1'b1;
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = rp_reg;

        case (state_reg)
            sset_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next   = KEY_WIDTH'(key);
                    idx_next   = index;
                    left_next  = '0;
                    right_next = count_reg;
                    case (cmd)
                        sset_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                            res_next   = '{status:   sset_pkg::STAT_CLEARED,
                                           position: '0, total: '0, read_key: '0};
                        end
                        sset_pkg::CMD_READ:
                        begin
                            if (in_range)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(index);
                            end
                            else
                            begin
                                res_next = '{status:   sset_pkg::STAT_OUT_OF_RANGE,
                                             position: index,
                                             total:    sset_pkg::TOTAL_W'(count_reg),
                                             read_key: '0};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sset_pkg::S_SRCH_RD:
            begin
                // Probe the midpoint, or settle the outcome of the search
                if (left_reg < right_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = mid_calc;
                    mid_next    = mid_calc;
                end
                else if (count_reg >= CAP_C)
                begin
                    res_next = '{status:   sset_pkg::STAT_FULL, position: '0,
                                 total:    sset_pkg::TOTAL_W'(count_reg), read_key: '0};
                end
                else
                begin
                    rp_next      = AW'(count_reg - 1'b1);
                    reading_next = 1'b1;
                    pend_next    = 1'b0;
                end
            end
            sset_pkg::S_SRCH_CMP:
            begin
                // Narrow the window or report the key as held
                if (key_eq)
                begin
                    res_next = '{status:   sset_pkg::STAT_DUPLICATE,
                                 position: sset_pkg::IDX_W'(mid_reg),
                                 total:    sset_pkg::TOTAL_W'(count_reg), read_key: '0};
                end
                else if (key_lt)
                begin
                    right_next = CW'(mid_reg);
                end
                else
                begin
                    left_next = CW'(mid_reg) + 1'b1;
                end
            end
            sset_pkg::S_SHIFT:
            begin
                // Write back the entry read last cycle one place higher
                if (pend_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = last_reg + 1'b1;
                    ram_wr_data = ram_rd_data;
                end
                // Read the next lower entry until the insert place is reached
                if (reading_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rp_reg;
                    last_next   = rp_reg;
                    pend_next   = 1'b1;
                    if (CW'(rp_reg) == left_reg)
                    begin
                        reading_next = 1'b0;
                    end
                    else
                    begin
                        rp_next = rp_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            sset_pkg::S_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(left_reg);
                ram_wr_data = key_reg;
                count_next  = count_reg + 1'b1;
                res_next    = '{status:   sset_pkg::STAT_INSERTED,
                                position: sset_pkg::IDX_W'(left_reg),
                                total:    sset_pkg::TOTAL_W'(count_reg + 1'b1),
                                read_key: '0};
            end
            sset_pkg::S_READ_WAIT:
            begin
                res_next = '{status:   sset_pkg::STAT_READ_OK, position: idx_reg,
                             total:    sset_pkg::TOTAL_W'(count_reg),
                             read_key: sset_pkg::KEYIO_W'(ram_rd_data)};
            end
            sset_pkg::S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sset_pkg::S_IDLE;
            count_reg   <= '0;
            reading_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            reading_reg <= reading_next;
            pend_reg    <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        mid_reg   <= mid_next;
        rp_reg    <= rp_next;
        last_reg  <= last_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

### src/sorted_set_insert.sv
// Sorted key set: keys kept in ascending signed order, inserted without duplicates.
//
// Command channel (in_valid/in_ready, cmd/key/index) takes one transaction at a
// time: insert a key, clear the set, or read the entry at an index. Each command
// but the unused code yields exactly one result transaction (out_valid/out_ready,
// status/position/entry_total/read_key); the unused code is taken and dropped.
// An insert bisects the held keys with one store read per probe; on a duplicate
// it ends when the key is found, and with the store full it drops the key once
// the search ends. Otherwise it moves the entries at and above the insert place
// up by one place, one entry moved per cycle in the shift-up, and writes the new
// key last. Clear and read need no search. After handing off a result the engine
// returns to its idle state before it takes the next command. All steps use the
// single store memory, which serves one read and one write at a time.
// A finished result sits in an output register, so the engine takes the next
// command while the receiver stalls; it holds its own next result until that
// register frees. Reset empties the set and drops any pending result; the store
// contents are left as they are and are never read before being written.
`default_nettype none

module sorted_set_insert #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [sset_pkg::CMD_W-1:0]            cmd,
    input  wire logic signed [sset_pkg::KEYIO_W-1:0]   key,
    input  wire logic [sset_pkg::IDX_W-1:0]            index,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sset_pkg::STAT_W-1:0]                status,
    output logic [sset_pkg::IDX_W-1:0]                 position,
    output logic [sset_pkg::TOTAL_W-1:0]               entry_total,
    output logic signed [sset_pkg::KEYIO_W-1:0]        read_key
);

    localparam int AW = $clog2(CAPACITY);

    logic                   res_valid;
    logic                   res_ready;
    sset_pkg::sset_result_t res;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [KEY_WIDTH-1:0]   ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [KEY_WIDTH-1:0]   ram_rd_data;

    logic                   out_valid_reg, out_valid_next;
    sset_pkg::sset_result_t out_reg, out_next;

    sset_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .index       (index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    sset_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign position    = out_reg.position;
    assign entry_total = out_reg.total;
    assign read_key    = $signed(out_reg.read_key);

    // Engine works on one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd != sset_pkg::CMD_UNUSED) |=> !in_ready)
        else $error("command taken while engine busy");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= sset_pkg::STAT_OUT_OF_RANGE))
        else $error("undefined status code");

    // A dropped insert only happens with the store full
    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sset_pkg::STAT_FULL) && (CAPACITY <= 64)
        |-> (entry_total == sset_pkg::TOTAL_W'(CAPACITY)))
        else $error("full drop with store not full");

    // An inserted key lands below the new count
    a_insert_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sset_pkg::STAT_INSERTED) && (CAPACITY <= 64)
        |-> ({1'b0, position} < entry_total))
        else $error("insert position beyond count");

endmodule

`default_nettype wire
